>>> sv/gbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the glyph bitmap text renderer
// Holds the item codes, configuration register indexes, queue sizing and the
// work entry that travels from the front part to the pixel serializer.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // Input item codes.
  localparam logic OP_BEGIN      = 1'b0;
  localparam logic OP_GLYPH_BYTE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAWING_COLOR = 1'b1;

  // Work queue between the classifier and the serializer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One bitmap byte that paints at least one on-screen pixel. The mask holds
  // only the bits that land on the screen. x_lo is the low ten bits of the
  // column of bit 0; bit l paints at x_lo - l.
  typedef struct packed {
    logic [7:0] mask;
    logic [9:0] x_lo;
    logic [9:0] y;
  } work_t;

  // Pen advance with saturation at the largest positive 16-bit value.
  function automatic logic [15:0] pen_advance(input logic [15:0] pen,
                                              input logic [7:0]  w);
    logic [16:0] nx;
    nx = {pen[15], pen} + {9'b0, w};
    if (!nx[16] && nx[15]) begin
      pen_advance = 16'h7FFF;
    end else begin
      pen_advance = nx[15:0];
    end
  endfunction

endpackage

>>> sv/gbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_front: item classifier and pen tracker
// Accepts begin items and glyph record bytes, keeps the pen and the glyph
// walk, and queues each bitmap byte that paints on-screen pixels.
// ----------------------------------------------------------------------------
module gbr_front #(
  parameter int SCREEN_W       = 1024,
  parameter int SCREEN_H       = 1024,
  parameter int MAX_GLYPH_ROWS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_op,
  input  logic signed [15:0]  in_start_x,
  input  logic signed [15:0]  in_start_y,
  input  logic [7:0]          in_glyph_byte,
  input  logic [6:0]          glyph_height,
  output logic                push,
  output gbr_pkg::work_t      push_entry
);

  localparam logic signed [17:0] SCREEN_W_S = 18'(SCREEN_W);
  localparam logic signed [16:0] SCREEN_H_S = 17'(SCREEN_H);
  localparam logic [6:0]         ROW_LIMIT  = 7'(MAX_GLYPH_ROWS);

  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;
  logic [7:0]  cur_width_r, cur_width_nxt;
  logic [5:0]  row_index_r, row_index_nxt;
  logic [4:0]  byte_index_r, byte_index_nxt;
  logic        awaiting_r, awaiting_nxt;

  logic               accept;
  logic [6:0]         rows;
  logic [8:0]         width_plus7;
  logic [5:0]         per_row;
  logic [5:0]         byte_plus1;
  logic [6:0]         row_plus1;
  logic signed [17:0] base_x;
  logic signed [16:0] pix_y;
  logic               y_on;
  logic signed [17:0] bit_x [8];
  logic [7:0]         hit;

  assign accept      = in_valid && !in_stall;
  assign rows        = (glyph_height > ROW_LIMIT) ? ROW_LIMIT : glyph_height;
  assign width_plus7 = {1'b0, cur_width_r} + 9'd7;
  assign per_row     = width_plus7[8:3];
  assign byte_plus1  = {1'b0, byte_index_r} + 6'd1;
  assign row_plus1   = {1'b0, row_index_r} + 7'd1;

  // Column of bit 0 of the current byte, and the row of the current line.
  assign base_x = $signed({{2{pen_x_r[15]}}, pen_x_r}) + $signed({9'b0, byte_plus1, 3'b000});
  assign pix_y  = $signed({pen_y_r[15], pen_y_r}) + $signed({11'b0, row_index_r});
  assign y_on   = !pix_y[16] && (pix_y < SCREEN_H_S);

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      bit_x[l] = base_x - 18'(l);
      hit[l]   = in_glyph_byte[l] && y_on && !bit_x[l][17] && (bit_x[l] < SCREEN_W_S);
    end
  end

  assign push = accept && (in_op == gbr_pkg::OP_GLYPH_BYTE) && !awaiting_r && (hit != 8'd0);
  assign push_entry.mask = hit;
  assign push_entry.x_lo = base_x[9:0];
  assign push_entry.y    = pix_y[9:0];

  always_comb begin
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    cur_width_nxt  = cur_width_r;
    row_index_nxt  = row_index_r;
    byte_index_nxt = byte_index_r;
    awaiting_nxt   = awaiting_r;
    if (accept) begin
      if (in_op == gbr_pkg::OP_BEGIN) begin
        pen_x_nxt      = in_start_x;
        pen_y_nxt      = in_start_y;
        awaiting_nxt   = 1'b1;
        row_index_nxt  = '0;
        byte_index_nxt = '0;
      end else if (awaiting_r) begin
        cur_width_nxt  = in_glyph_byte;
        row_index_nxt  = '0;
        byte_index_nxt = '0;
        if ((in_glyph_byte == 8'd0) || (rows == 7'd0)) begin
          // An empty glyph finishes on its width byte.
          pen_x_nxt = gbr_pkg::pen_advance(pen_x_r, in_glyph_byte);
        end else begin
          awaiting_nxt = 1'b0;
        end
      end else if (byte_plus1 >= per_row) begin
        byte_index_nxt = '0;
        if (row_plus1 >= rows) begin
          pen_x_nxt     = gbr_pkg::pen_advance(pen_x_r, cur_width_r);
          awaiting_nxt  = 1'b1;
          row_index_nxt = '0;
        end else begin
          row_index_nxt = row_plus1[5:0];
        end
      end else begin
        byte_index_nxt = byte_plus1[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      cur_width_r  <= '0;
      row_index_r  <= '0;
      byte_index_r <= '0;
      awaiting_r   <= 1'b1;
    end else begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      cur_width_r  <= cur_width_nxt;
      row_index_r  <= row_index_nxt;
      byte_index_r <= byte_index_nxt;
      awaiting_r   <= awaiting_nxt;
    end
  end

endmodule

>>> sv/gbr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_queue: work queue between classifier and serializer
// A small circular buffer of work entries with a fill count.
// ----------------------------------------------------------------------------
module gbr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gbr_pkg::work_t push_entry,
  input  logic           pop,
  output gbr_pkg::work_t head,
  output logic           empty,
  output logic           full
);

  gbr_pkg::work_t                  slot_r [gbr_pkg::QUEUE_DEPTH];
  logic [gbr_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [gbr_pkg::QCNT_W-1:0]      count_r;
  logic                            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == gbr_pkg::QCNT_W'(gbr_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + gbr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + gbr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + gbr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - gbr_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> sv/gbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_back: pixel serializer
// Walks the set bits of each queued byte from bit 0 upward and presents one
// pixel per cycle in the output register while out_stall is low.
// ----------------------------------------------------------------------------
module gbr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  gbr_pkg::work_t head,
  input  logic           empty,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [9:0]     out_pixel_x,
  output logic [9:0]     out_pixel_y,
  output logic           out_last
);

  function automatic logic [2:0] lowest_bit(input logic [7:0] m);
    lowest_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        lowest_bit = 3'(i);
      end
    end
  endfunction

  logic [7:0] cur_mask_r;
  logic [9:0] cur_x_r, cur_y_r;
  logic       out_valid_r;
  logic [9:0] out_x_r, out_y_r;
  logic       out_last_r;

  logic       busy, adv, emit, load;
  logic [7:0] rest;
  logic [2:0] bit_l;

  assign busy  = (cur_mask_r != 8'd0);
  assign adv   = !out_valid_r || !out_stall;
  assign emit  = adv && busy;
  assign rest  = cur_mask_r & (cur_mask_r - 8'd1);
  assign bit_l = lowest_bit(cur_mask_r);
  // Load the next byte as soon as the current one has shown its final pixel.
  assign load  = !empty && (!busy || (emit && (rest == 8'd0)));
  assign pop   = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x_r <= head.x_lo;
      cur_y_r <= head.y;
    end
    if (emit) begin
      out_x_r    <= cur_x_r - {7'b0, bit_l};
      out_y_r    <= cur_y_r;
      out_last_r <= (rest == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_mask_r <= head.mask;
      end else if (emit) begin
        cur_mask_r <= rest;
      end
      if (adv) begin
        out_valid_r <= busy;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_last    = out_last_r;

endmodule

>>> sv/glyph_bitmap_text_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_text_renderer_unit: glyph records to clipped pixel writes
// Front part tracks the pen and glyph walk, a work queue decouples it from a
// serializer that emits one pixel per cycle unless stalled, in the drawing color.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    op, start_x, start_y, glyph_byte
//   out_     output     out_valid/out_stall  pixel_x, pixel_y, red, green, blue, last
//   cfg_     input      cfg_valid/cfg_ready  index, data (ready is always high)
//
// An input transfer is taken whenever the four-entry work queue has room.
// A bitmap byte with n on-screen pixels yields n pixel writes (one to eight);
// other items add no work. With the serializer idle, a byte passes through the
// work queue and the current-byte register before its first pixel is presented.
// Synchronous reset clears pen, glyph walk, queue and output, with glyph_height
// 10 and drawing_color 0. A held out_stall fills the queue and raises in_stall.
// ----------------------------------------------------------------------------
module glyph_bitmap_text_renderer_unit #(
  parameter int SCREEN_W       = 1024,
  parameter int SCREEN_H       = 1024,
  parameter int MAX_GLYPH_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic signed [15:0]               in_start_x,
  input  logic signed [15:0]               in_start_y,
  input  logic [7:0]                       in_glyph_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [9:0]                       out_pixel_x,
  output logic [9:0]                       out_pixel_y,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [23:0]                      cfg_data
);

  logic [6:0]     glyph_height_r;
  logic [23:0]    drawing_color_r;

  logic           push, pop, q_empty, q_full;
  gbr_pkg::work_t push_entry, head;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this, and both sides read them directly.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_height_r  <= 7'd10;
      drawing_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gbr_pkg::REG_GLYPH_HEIGHT:  glyph_height_r  <= cfg_data[6:0];
        gbr_pkg::REG_DRAWING_COLOR: drawing_color_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input side only waits when the work queue is full.
  assign in_stall = q_full;

  gbr_front #(
    .SCREEN_W       (SCREEN_W),
    .SCREEN_H       (SCREEN_H),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_glyph_byte (in_glyph_byte),
    .glyph_height  (glyph_height_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  gbr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  gbr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_last    (out_last)
  );

  // Every pixel carries the current drawing color.
  assign out_red   = drawing_color_r[23:16];
  assign out_green = drawing_color_r[15:8];
  assign out_blue  = drawing_color_r[7:0];

endmodule

>>> sv/gbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_checker: port-level checks of the glyph bitmap text renderer
// Watches the top-level ports and flags ordering and reset slips.
// ----------------------------------------------------------------------------
module gbr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [9:0]                    out_pixel_x,
  input logic [9:0]                    out_pixel_y,
  input logic                          out_last
);

  // A stalled pixel holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x)
      && $stable(out_pixel_y) && $stable(out_last))
    else $error("stalled pixel changed");

  // Pixels of one byte follow without a gap and share a row.
  a_byte_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid
      && (out_pixel_y == $past(out_pixel_y)))
    else $error("pixel burst of a byte broken");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the work queue, so input is taken right away.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind glyph_bitmap_text_renderer_unit gbr_checker u_gbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_pixel_x (out_pixel_x),
  .out_pixel_y (out_pixel_y),
  .out_last    (out_last)
);
